// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and defaults for the text console writer: transaction
// payloads, operation codes, character codes and controller/datapath links.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Default geometry
	localparam int COLUMNS_DEF   = 80;
	localparam int ROWS_DEF      = 25;
	localparam int TAB_WIDTH_DEF = 8;

	// Fixed payload widths
	localparam int OP_W    = 2;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int LOC_W   = 12;
	localparam int CELL_W  = CHAR_W + ATTR_W;

	// Blank attribute after reset
	localparam logic [ATTR_W-1:0] BLANK_RESET = 8'd240;

	// Character codes with special meaning
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	typedef enum logic [OP_W-1:0] {
		OP_PUT    = 2'd0,
		OP_SCROLL = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CHAR_W-1:0]  char_code;
		logic [ATTR_W-1:0]  color;
		logic [INDEX_W-1:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [LOC_W-1:0]  cursor_location;
		logic [CELL_W-1:0] cell_data;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;     // latch the input transaction
		logic exec;       // evaluate the latched operation
		logic read_issue; // read the addressed cell
		logic cur_move;   // apply a cursor-only control character
		logic cur_print;  // write the character and advance the cursor
		logic pre_scroll; // wrap column and park the row on the last line
		logic sweep_clr;  // restart the cell sweep counter
		logic copy_rd;    // scroll: read the cell one row below
		logic copy_wr;    // scroll: write it one row up
		logic fill_wr;    // scroll: blank the bottom row
		logic clear_wr;   // clear: blank a cell
		logic home;       // cursor to row 0, column 0
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic put_move;
		logic put_scroll;
		logic last_copy;
		logic last_cell;
	} stat_t;

endpackage

// ----- sv/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller for the text console writer: sequences operation execution,
// the scroll copy/fill sweep and the clear sweep, and strobes completion.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tcw_pkg::stat_t stat,
	output tcw_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_EXEC    = 7'b0000010,
		S_COPY_RD = 7'b0000100,
		S_COPY_WR = 7'b0001000,
		S_FILL    = 7'b0010000,
		S_CLEAR   = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE, S_DONE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				case (stat.op)
					tcw_pkg::OP_PUT: begin
						if (stat.put_scroll) begin
							cmd.pre_scroll = 1'b1;
							cmd.sweep_clr  = 1'b1;
							state_d        = S_COPY_RD;
						end else if (stat.put_move) begin
							cmd.cur_move = 1'b1;
							state_d      = S_DONE;
						end else begin
							cmd.cur_print = 1'b1;
							state_d       = S_DONE;
						end
					end
					tcw_pkg::OP_SCROLL: begin
						cmd.sweep_clr = 1'b1;
						state_d       = S_COPY_RD;
					end
					tcw_pkg::OP_CLEAR: begin
						cmd.sweep_clr = 1'b1;
						state_d       = S_CLEAR;
					end
					tcw_pkg::OP_READ: begin
						cmd.read_issue = 1'b1;
						state_d        = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_COPY_RD: begin
				cmd.copy_rd = 1'b1;
				state_d     = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d     = stat.last_copy ? S_FILL : S_COPY_RD;
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (stat.last_cell) begin
					// a put that forced the scroll still has its character to write
					state_d = (stat.op == tcw_pkg::OP_PUT) ? S_EXEC : S_DONE;
				end
			end
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.last_cell) begin
					cmd.home = 1'b1;
					state_d  = S_DONE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = !(state_q == S_IDLE || state_q == S_DONE);
	assign done = (state_q == S_DONE);

endmodule

// ----- sv/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath for the text console writer: latched transaction, cursor,
// blank attribute, sweep counter, character store and result formatting.
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcw_pkg::cmd_t                  cmd,
	output tcw_pkg::stat_t                 stat,
	input  tcw_pkg::req_t                  req,
	input  logic                           cfg_valid,
	input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data,
	output tcw_pkg::rsp_t                  result
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int LW    = $clog2(CELLS + COLUMNS + 1);

	tcw_pkg::req_t                req_q;
	logic [tcw_pkg::ATTR_W-1:0]   blank_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [AW-1:0]                idx_q;
	logic                         rd_flag_q;

	logic                         is_nl, is_bs, is_tab, is_cr, moves;
	logic                         wrap, scroll_need;
	logic [CW-1:0]                col_w;
	logic [RW-1:0]                row_eff;
	logic [CW-1:0]                tab_next;
	logic [CW-1:0]                move_col;
	logic [RW-1:0]                move_row;
	logic [AW-1:0]                print_addr;
	logic                         in_range;
	logic                         we, re;
	logic [AW-1:0]                waddr, raddr;
	logic [tcw_pkg::CELL_W-1:0]   wdata, rdata;
	logic [LW-1:0]                loc;

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
	end

	// Blank attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= tcw_pkg::BLANK_RESET;
		end else if (cfg_valid) begin
			blank_q <= cfg_data;
		end
	end

	// Decode control characters
	assign is_nl  = (req_q.char_code == tcw_pkg::CH_NL);
	assign is_bs  = (req_q.char_code == tcw_pkg::CH_BS) && (col_q != '0);
	assign is_tab = (req_q.char_code == tcw_pkg::CH_TAB);
	assign is_cr  = (req_q.char_code == tcw_pkg::CH_CR);
	assign moves  = is_nl || is_bs || is_tab || is_cr;

	// Wrap at the right edge; scroll when the row runs off the bottom
	assign wrap        = (32'(col_q) >= 32'(COLUMNS));
	assign col_w       = wrap ? '0 : col_q;
	assign row_eff     = row_q + RW'(wrap);
	assign scroll_need = (32'(row_q) >= 32'(ROWS)) ||
		(wrap && (32'(row_q) >= 32'(ROWS - 1)));

	// Next tab stop, saturating at the right edge
	always_comb begin
		tab_next = CW'(COLUMNS);
		for (int k = COLUMNS / TAB_WIDTH; k >= 1; k--) begin
			if (k * TAB_WIDTH > 32'(col_q)) begin
				tab_next = CW'(k * TAB_WIDTH);
			end
		end
	end

	// Cursor after a control character
	always_comb begin
		move_col = col_q;
		move_row = row_q;
		if (is_nl) begin
			move_col = '0;
			if (32'(row_q) < 32'(ROWS)) begin
				move_row = row_q + RW'(1);
			end
		end else if (is_bs) begin
			move_col = col_q - CW'(1);
		end else if (is_tab) begin
			move_col = tab_next;
		end else if (is_cr) begin
			move_col = '0;
		end
	end

	assign print_addr = AW'(row_eff) * AW'(COLUMNS) + AW'(col_w);

	// Cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.home) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.cur_move) begin
			col_q <= move_col;
			row_q <= move_row;
		end else if (cmd.cur_print) begin
			col_q <= col_w + CW'(1);
			row_q <= row_eff;
		end else if (cmd.pre_scroll) begin
			col_q <= col_w;
			row_q <= RW'(ROWS - 1);
		end
	end

	// Sweep counter for scroll and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.sweep_clr) begin
			idx_q <= '0;
		end else if (cmd.copy_wr || cmd.fill_wr || cmd.clear_wr) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Mark whether the result carries read data
	assign in_range = (32'(req_q.cell_index) < 32'(CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_flag_q <= 1'b0;
		end else if (cmd.exec) begin
			rd_flag_q <= (req_q.op == tcw_pkg::OP_READ) && in_range;
		end
	end

	// Store port selection
	assign we    = cmd.cur_print || cmd.copy_wr || cmd.fill_wr || cmd.clear_wr;
	assign waddr = cmd.cur_print ? print_addr : idx_q;
	assign re    = cmd.read_issue || cmd.copy_rd;
	assign raddr = cmd.copy_rd ? (idx_q + AW'(COLUMNS)) : AW'(req_q.cell_index);

	always_comb begin
		if (cmd.cur_print) begin
			wdata = {req_q.color, req_q.char_code};
		end else if (cmd.copy_wr) begin
			wdata = rdata;
		end else if (cmd.fill_wr) begin
			wdata = {blank_q, tcw_pkg::CH_NUL};
		end else begin
			wdata = {blank_q, tcw_pkg::CH_SPACE};
		end
	end

	tcw_ram #(
		.W     (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Status to the controller
	assign stat.op         = req_q.op;
	assign stat.put_move   = moves;
	assign stat.put_scroll = !moves && scroll_need;
	assign stat.last_copy  = (idx_q == AW'(CELLS - COLUMNS - 1));
	assign stat.last_cell  = (idx_q == AW'(CELLS - 1));

	// Result formatting
	assign loc                    = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);
	assign result.cursor_location = tcw_pkg::LOC_W'(loc);
	assign result.cell_data       = rd_flag_q ? rdata : '0;

endmodule

// ----- sv/text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console writer over a ROWS x COLUMNS store of attribute/character
// cells with a cursor: put character, scroll up, clear screen, read cell.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result is
// shown for exactly one cycle with done high and cannot be held off. Put and
// read pass from accept through the execute state to done; a new transaction
// is not taken while busy, but the next one may be started in the done cycle.
// The store has one write and one registered read port, which sets the
// sweeps: scroll reads then writes each moved cell and writes each bottom
// cell once, a put that runs off the last line scrolls first and writes its
// character after the sweep, and clear writes each cell once.
// The store contents are undefined after reset; clear the screen first.
// The user must write blank_attribute through cfg only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
	parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  tcw_pkg::req_t              req,
	output logic                       done,
	output tcw_pkg::rsp_t              result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);

	tcw_pkg::cmd_t  cmd;
	tcw_pkg::stat_t stat;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tcw_datapath #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	// An accepted transaction occupies the block in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// Each completion strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// A scroll write always follows its read of the row below
	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_wr |-> $past(cmd.copy_rd))
		else $error("scroll copy write without preceding read");

	// Clear completes right after homing the cursor
	a_home_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.home |=> done)
		else $error("clear finished without completion strobe");

endmodule

// ----- bench/text_console_writer_top_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the text console writer. A clocked driver plays a
// queue of operations into the command port and blank attribute writes into
// the cfg port. A clocked monitor runs every accepted transaction through a
// behavioral model of the screen and cursor, and compares each strobed
// result with the oldest expected one. A directed opening covers the
// corners, then random bursts of text, control characters, reads, scrolls
// and clears run under three sender idling profiles.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
	import tcw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS  = COLUMNS_DEF;
	localparam int ROWS  = ROWS_DEF;
	localparam int TABW  = TAB_WIDTH_DEF;
	localparam int CELLS = COLS * ROWS;

	// Minimum items per random phase; six phases
	localparam int PHASE_ITEMS = 225;

	typedef enum {ENTRY_ITEM, ENTRY_BLANK_WR, ENTRY_DRAIN} entry_kind_e;

	typedef struct {
		entry_kind_e       kind;
		req_t              item;
		logic [ATTR_W-1:0] blank;
		int                idle_pct;
	} console_entry_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	req_t              req = '0;
	logic              done;
	rsp_t              result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ATTR_W-1:0] cfg_data = '0;

	console_entry_t pending_ops[$];
	rsp_t           reply_q[$];
	int             error_count = 0;
	int             phase_items = 0;

	// Screen model state
	logic [CELL_W-1:0] screen_mem [CELLS];
	int unsigned       cur_col = 0;
	int unsigned       cur_row = 0;
	logic [ATTR_W-1:0] blank_attr = BLANK_RESET;

	text_console_writer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Screen model
	// ------------------------------------------------------------------------

	// Move every row up one and blank the bottom row with NULs
	function automatic void shift_screen_up();
		for (int i = 0; i < CELLS - COLS; i++)
			screen_mem[i] = screen_mem[i + COLS];
		for (int i = CELLS - COLS; i < CELLS; i++)
			screen_mem[i] = {blank_attr, CH_NUL};
	endfunction

	// Apply one transaction to the model and return the expected reply
	function automatic rsp_t console_step(req_t r);
		rsp_t        reply;
		int unsigned tab_stop;
		int unsigned addr;
		reply.cell_data = '0;
		case (r.op)
			OP_PUT: begin
				if (r.char_code == CH_NL) begin
					cur_col = 0;
					if (cur_row < ROWS)
						cur_row++;
				end else if (r.char_code == CH_BS && cur_col > 0) begin
					cur_col--;
				end else if (r.char_code == CH_TAB) begin
					tab_stop = (cur_col / TABW + 1) * TABW;
					cur_col = (tab_stop > COLS) ? COLS : tab_stop;
				end else if (r.char_code == CH_CR) begin
					cur_col = 0;
				end else begin
					// wrap, scroll off the bottom, then write and advance
					if (cur_col >= COLS) begin
						cur_col = 0;
						cur_row++;
					end
					if (cur_row >= ROWS) begin
						shift_screen_up();
						cur_row = ROWS - 1;
					end
					addr = cur_row * COLS + cur_col;
					if (addr < CELLS)
						screen_mem[addr] = {r.color, r.char_code};
					cur_col++;
				end
			end
			OP_SCROLL: begin
				shift_screen_up();
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_mem[i] = {blank_attr, CH_SPACE};
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
				if (r.cell_index < CELLS)
					reply.cell_data = screen_mem[r.cell_index];
			end
		endcase
		reply.cursor_location = LOC_W'(cur_row * COLS + cur_col);
		return reply;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------------

	function automatic req_t make_req(op_t op, logic [CHAR_W-1:0] ch,
			logic [ATTR_W-1:0] color, logic [INDEX_W-1:0] idx);
		req_t r;
		r.op = op;
		r.char_code = ch;
		r.color = color;
		r.cell_index = idx;
		return r;
	endfunction

	task automatic push_item(req_t r, int idle_pct);
		console_entry_t e;
		e.kind = ENTRY_ITEM;
		e.item = r;
		e.blank = '0;
		e.idle_pct = idle_pct;
		pending_ops.push_back(e);
		phase_items++;
	endtask

	task automatic push_marker(entry_kind_e kind, logic [ATTR_W-1:0] blank);
		console_entry_t e;
		e.kind = kind;
		e.item = '0;
		e.blank = blank;
		e.idle_pct = 0;
		pending_ops.push_back(e);
	endtask

	function automatic logic [INDEX_W-1:0] rand_index();
		if ($urandom_range(9) == 0)
			return INDEX_W'($urandom_range(2047, CELLS));
		return INDEX_W'($urandom_range(CELLS - 1));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_text_char();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return CH_NL;
		if (pick < 12)
			return CH_BS;
		if (pick < 18)
			return CH_TAB;
		if (pick < 22)
			return CH_CR;
		if (pick < 40)
			return CHAR_W'($urandom_range(255));
		return CHAR_W'($urandom_range(8'h7E, 8'h20));
	endfunction

	task automatic put_char(logic [CHAR_W-1:0] ch, int idle_pct);
		push_item(make_req(OP_PUT, ch, ATTR_W'($urandom_range(255)), INDEX_W'($urandom)),
			idle_pct);
	endtask

	// Append one random burst of related operations
	task automatic add_burst(int phase_idle);
		int idle_pct;
		int unsigned kind;
		int unsigned len;
		idle_pct = ($urandom_range(4) == 0) ? 0 : phase_idle;
		kind = $urandom_range(99);
		if (kind < 30) begin
			// text run with control characters mixed in
			len = $urandom_range(40, 1);
			repeat (len) put_char(rand_text_char(), idle_pct);
		end else if (kind < 45) begin
			len = $urandom_range(8, 1);
			repeat (len)
				push_item(make_req(OP_READ, CHAR_W'($urandom), ATTR_W'($urandom),
					rand_index()), idle_pct);
		end else if (kind < 55) begin
			// newlines, up to 30, which can pin the row at the bottom
			len = $urandom_range(30, 1);
			repeat (len) put_char(CH_NL, idle_pct);
			put_char(CHAR_W'($urandom_range(8'h7E, 8'h20)), idle_pct);
		end else if (kind < 65) begin
			// tabs up to and past the right edge, then print
			len = $urandom_range(12, 1);
			repeat (len) put_char(CH_TAB, idle_pct);
			put_char(CHAR_W'($urandom_range(255)), idle_pct);
		end else if (kind < 75) begin
			len = $urandom_range(10, 1);
			repeat (len) put_char(CH_BS, idle_pct);
			put_char(CHAR_W'($urandom_range(255)), idle_pct);
		end else if (kind < 85) begin
			// about a line of text, 70 to 85 characters, so the cursor may wrap
			len = $urandom_range(85, 70);
			repeat (len) put_char(CHAR_W'($urandom_range(8'h7E, 8'h20)), idle_pct);
		end else if (kind < 95) begin
			// noise: any field values on put and read
			len = $urandom_range(6, 1);
			repeat (len)
				push_item(make_req(($urandom_range(1) == 0) ? OP_PUT : OP_READ,
					CHAR_W'($urandom), ATTR_W'($urandom), INDEX_W'($urandom)),
					idle_pct);
		end else if (kind < 98) begin
			push_item(make_req(OP_SCROLL, CHAR_W'($urandom), ATTR_W'($urandom),
				INDEX_W'($urandom)), idle_pct);
			push_item(make_req(OP_READ, '0, '0,
				INDEX_W'($urandom_range(CELLS - 1, CELLS - COLS))), idle_pct);
		end else begin
			push_item(make_req(OP_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom),
				INDEX_W'($urandom)), idle_pct);
			push_item(make_req(OP_READ, '0, '0, rand_index()), idle_pct);
		end
	endtask

	// New blank attribute, a clear to show it, then random bursts
	task automatic add_phase(logic [ATTR_W-1:0] blank, int phase_idle);
		bit drained;
		drained = 1'b0;
		phase_items = 0;
		push_marker(ENTRY_BLANK_WR, blank);
		push_item(make_req(OP_CLEAR, '0, '0, '0), phase_idle);
		push_item(make_req(OP_READ, '0, '0, INDEX_W'($urandom_range(CELLS - 1))),
			phase_idle);
		while (phase_items < PHASE_ITEMS) begin
			add_burst(phase_idle);
			if (!drained && phase_items > PHASE_ITEMS / 2) begin
				push_marker(ENTRY_DRAIN, '0);
				drained = 1'b1;
			end
		end
	endtask

	task automatic add_directed();
		push_item(make_req(OP_CLEAR, '0, '0, '0), 0);
		push_item(make_req(OP_READ, '0, '0, '0), 0);
		push_item(make_req(OP_READ, '0, '0, INDEX_W'(CELLS - 1)), 0);
		push_item(make_req(OP_READ, '0, '0, INDEX_W'(CELLS)), 0);
		push_item(make_req(OP_READ, 8'hFF, 8'hFF, 11'h7FF), 0);
		push_item(make_req(OP_PUT, 8'h41, 8'hFF, '0), 0);
		push_item(make_req(OP_PUT, CH_NUL, 8'h00, '0), 0);
		push_item(make_req(OP_PUT, CH_BS, 8'h11, '0), 0);
		push_item(make_req(OP_PUT, CH_BS, 8'h22, '0), 0);
		// backspace at column zero prints
		push_item(make_req(OP_PUT, CH_BS, 8'h33, '0), 0);
		push_item(make_req(OP_READ, '0, '0, '0), 0);
		push_item(make_req(OP_PUT, CH_TAB, 8'h00, '0), 0);
		push_item(make_req(OP_PUT, CH_CR, 8'h00, '0), 0);
		push_item(make_req(OP_PUT, CH_NL, 8'h00, '0), 0);
		push_item(make_req(OP_PUT, 8'hFF, 8'hAA, 11'h7FF), 0);
		push_item(make_req(OP_READ, '0, '0, INDEX_W'(COLS)), 0);
		push_item(make_req(OP_SCROLL, 8'h55, 8'h55, 11'h555), 0);
		push_item(make_req(OP_READ, '0, '0, '0), 0);
		push_item(make_req(OP_READ, '0, '0, INDEX_W'(CELLS - COLS)), 0);
		push_item(make_req(OP_READ, '0, '0, INDEX_W'(COLS)), 0);
	endtask

	// ------------------------------------------------------------------------
	// Driver: play the operation queue into the command and blank ports
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : driver_proc
		bit free;
		console_entry_t head;
		if (arst_n) begin
			free = 1'b1;
			if (cfg_valid) begin
				free = 1'b0;
				if (cfg_ready)
					cfg_valid <= 1'b0;
			end else if (start) begin
				free = !busy;
			end
			if (free) begin
				if (pending_ops.size() == 0) begin
					start <= 1'b0;
				end else begin
					head = pending_ops[0];
					case (head.kind)
						ENTRY_ITEM: begin
							if ($urandom_range(99) < head.idle_pct) begin
								start <= 1'b0;
							end else begin
								start <= 1'b1;
								req <= head.item;
								void'(pending_ops.pop_front());
							end
						end
						ENTRY_BLANK_WR: begin
							// write only with nothing in flight
							start <= 1'b0;
							if (!start && !busy && reply_q.size() == 0) begin
								cfg_valid <= 1'b1;
								cfg_data <= head.blank;
								void'(pending_ops.pop_front());
							end
						end
						default: begin
							// hold off until every reply is back
							start <= 1'b0;
							if (!start && !busy && reply_q.size() == 0)
								void'(pending_ops.pop_front());
						end
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check replies, predict accepted transactions
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : monitor_proc
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (reply_q.size() == 0) begin
					report_mismatch($sformatf("unexpected reply loc=%0d data=%h",
						result.cursor_location, result.cell_data));
				end else begin
					want = reply_q.pop_front();
					if (result.cursor_location !== want.cursor_location)
						report_mismatch($sformatf("cursor_location got %0d want %0d",
							result.cursor_location, want.cursor_location));
					if (result.cell_data !== want.cell_data)
						report_mismatch($sformatf("cell_data got %h want %h",
							result.cell_data, want.cell_data));
				end
			end
			if (start && !busy)
				reply_q.push_back(console_step(req));
			if (cfg_valid && cfg_ready)
				blank_attr = cfg_data;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: build stimulus, reset, wait for drain, report
	// ------------------------------------------------------------------------
	initial begin
		add_directed();
		add_phase(8'h00, 23);
		add_phase(8'hFF, 23);
		add_phase(ATTR_W'($urandom_range(255)), 80);
		add_phase(BLANK_RESET, 80);
		add_phase(ATTR_W'($urandom_range(255)), 0);
		add_phase(8'hFF, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_ops.size() != 0 || start || reply_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Bound the run well beyond the slowest legal case
	initial begin
		#250_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
